[rtl/delta_list_timer_queue_macros.svh]
// assertion helpers; they expect clk and rst_n in the enclosing scope
`ifndef DELTA_LIST_TIMER_QUEUE_MACROS_SVH
`define DELTA_LIST_TIMER_QUEUE_MACROS_SVH

// condition holds at every edge out of reset
`define DLTQ_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define DLTQ_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define DLTQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/dltq_pkg.sv]
`timescale 1ns / 1ps

package dltq_pkg;

    // fixed field widths
    localparam int TIME_W  = 48;
    localparam int ID_W    = 8;
    localparam int DELAY_W = 40;

    // default sizing
    localparam int DLTQ_ENTRY_COUNT = 16;
    localparam int DLTQ_DELTA_BITS  = 40;

    typedef enum logic [1:0] {
        FUNC_SYNC   = 2'd0,
        FUNC_ADD    = 2'd1,
        FUNC_REMOVE = 2'd2,
        FUNC_ALARM  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_FULL    = 2'd1,
        STATUS_DUP     = 2'd2,
        STATUS_MISSING = 2'd3
    } status_t;

    typedef enum logic {
        ALU_SUB     = 1'b0,
        ALU_ADD_SAT = 1'b1
    } alu_op_t;

    // per-field write enables of the slot memory
    typedef struct packed {
        logic id_en;
        logic delta_en;
        logic link_en;
    } slot_we_t;

endpackage

[rtl/dltq_ifs.sv]
`timescale 1ns / 1ps

// request channel: one timer command per beat
interface dltq_req_if import dltq_pkg::*; ();
    logic               valid;
    logic               ready;
    func_t              func;
    logic [TIME_W-1:0]  now_time;
    logic [ID_W-1:0]    entry_id;
    logic [DELAY_W-1:0] delay;

    modport source (output valid, func, now_time, entry_id, delay, input ready);
    modport sink   (input valid, func, now_time, entry_id, delay, output ready);
endinterface

// response channel: one result per command
interface dltq_rsp_if import dltq_pkg::*; ();
    logic            valid;
    logic            ready;
    status_t         status;
    logic            expired_valid;
    logic [ID_W-1:0] expired_id;

    modport source (output valid, status, expired_valid, expired_id, input ready);
    modport sink   (input valid, status, expired_valid, expired_id, output ready);
endinterface

[rtl/dltq_slot_mem.sv]
`timescale 1ns / 1ps

module dltq_slot_mem import dltq_pkg::*; #(
    parameter int ENTRY_COUNT = DLTQ_ENTRY_COUNT,
    parameter int DELTA_BITS  = DLTQ_DELTA_BITS,
    localparam int IDX_W      = $clog2(ENTRY_COUNT)
) (
    input  logic                  clk,
    input  logic                  rd_en,
    input  logic [IDX_W-1:0]      rd_addr,
    output logic [ID_W-1:0]       rd_id,
    output logic [DELTA_BITS-1:0] rd_delta,
    output logic [IDX_W-1:0]      rd_link,
    input  slot_we_t              we,
    input  logic [IDX_W-1:0]      wr_addr,
    input  logic [ID_W-1:0]       wr_id,
    input  logic [DELTA_BITS-1:0] wr_delta,
    input  logic [IDX_W-1:0]      wr_link
);

    logic [ID_W-1:0]       id_mem    [ENTRY_COUNT];
    logic [DELTA_BITS-1:0] delta_mem [ENTRY_COUNT];
    logic [IDX_W-1:0]      link_mem  [ENTRY_COUNT];

    // write port, one field mask per array
    always_ff @(posedge clk)
    begin
        if (we.id_en)
        begin
            id_mem[wr_addr] <= wr_id;
        end
        if (we.delta_en)
        begin
            delta_mem[wr_addr] <= wr_delta;
        end
        if (we.link_en)
        begin
            link_mem[wr_addr] <= wr_link;
        end
    end

    // registered read port, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_id    <= id_mem[rd_addr];
            rd_delta <= delta_mem[rd_addr];
            rd_link  <= link_mem[rd_addr];
        end
    end

endmodule

[rtl/dltq_alu.sv]
`timescale 1ns / 1ps

module dltq_alu import dltq_pkg::*; #(
    parameter int DELTA_BITS = DLTQ_DELTA_BITS
) (
    input  alu_op_t               op,
    input  logic [DELTA_BITS-1:0] a,
    input  logic [DELTA_BITS-1:0] b,
    output logic [DELTA_BITS-1:0] res,
    output logic                  ge
);

    logic [DELTA_BITS:0]   sum;
    logic [DELTA_BITS-1:0] diff;

    // one adder path: difference with compare, or saturating sum
    always_comb
    begin
        sum  = {1'b0, a} + {1'b0, b};
        diff = a - b;
        ge   = (a >= b);
        case (op)
            ALU_SUB:     res = diff;
            ALU_ADD_SAT: res = sum[DELTA_BITS] ? '1 : sum[DELTA_BITS-1:0];
            default:     res = diff;
        endcase
    end

endmodule

[rtl/delta_list_timer_queue.sv]
// throughput: one command at a time, set by the walk over the linked slot
// memory at one entry per cycle through its single read port
// reset: asynchronous, empties the queue and clears the time base to zero
`timescale 1ns / 1ps
`include "delta_list_timer_queue_macros.svh"

module delta_list_timer_queue import dltq_pkg::*; #(
    parameter int ENTRY_COUNT = DLTQ_ENTRY_COUNT,
    parameter int DELTA_BITS  = DLTQ_DELTA_BITS
) (
    input  logic              clk,
    input  logic              rst_n,
    dltq_req_if.sink          req,
    dltq_rsp_if.source        rsp
);

    localparam int IDX_W = $clog2(ENTRY_COUNT);
    localparam int CNT_W = $clog2(ENTRY_COUNT + 1);
    localparam int XW    = (DELTA_BITS > TIME_W) ? DELTA_BITS : TIME_W;
    localparam int DW    = (DELTA_BITS > DELAY_W) ? DELTA_BITS : DELAY_W;
    localparam logic [DELTA_BITS-1:0] DELTA_MAX = '1;

    typedef enum logic [4:0] {
        S_IDLE,
        S_ADV_START,
        S_ADV_WALK,
        S_ADV_FIX,
        S_ADD_CHK,
        S_DUP_WALK,
        S_FREE_SCAN,
        S_INS_START,
        S_INS_WALK,
        S_INS_FIX,
        S_INS_NEW,
        S_INS_LINK,
        S_RM_START,
        S_RM_WALK,
        S_RM_SUM,
        S_RM_LINK,
        S_AL_START,
        S_AL_CHK,
        S_DONE
    } state_t;

    // control state
    state_t             state_reg, state_next;
    func_t              func_reg, func_next;
    logic [IDX_W-1:0]   head_reg, head_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [TIME_W-1:0]  last_sync_reg, last_sync_next;
    logic [ENTRY_COUNT-1:0] used_reg, used_next;
    logic [CNT_W-1:0]   step_reg, step_next;
    logic               has_prev_reg, has_prev_next;
    logic               adv_done_reg, adv_done_next;
    status_t            status_reg, status_next;
    logic               exp_valid_reg, exp_valid_next;
    logic [ID_W-1:0]    exp_id_reg, exp_id_next;
    logic               out_valid_reg, out_valid_next;
    status_t            out_status_reg, out_status_next;
    logic               out_exp_valid_reg, out_exp_valid_next;
    logic [ID_W-1:0]    out_exp_id_reg, out_exp_id_next;

    // working data
    logic [TIME_W-1:0]     now_reg, now_next;
    logic [ID_W-1:0]       id_reg, id_next;
    logic [DELAY_W-1:0]    delay_reg, delay_next;
    logic [DELTA_BITS-1:0] acc_reg, acc_next;
    logic [IDX_W-1:0]      cur_reg, cur_next;
    logic [IDX_W-1:0]      prev_reg, prev_next;
    logic [IDX_W-1:0]      slot_reg, slot_next;

    // memory and alu hookup
    logic                  mem_rd_en;
    logic [IDX_W-1:0]      mem_rd_addr;
    logic [ID_W-1:0]       q_id;
    logic [DELTA_BITS-1:0] q_delta;
    logic [IDX_W-1:0]      q_link;
    slot_we_t              mem_we;
    logic [IDX_W-1:0]      mem_wr_addr;
    logic [ID_W-1:0]       mem_wr_id;
    logic [DELTA_BITS-1:0] mem_wr_delta;
    logic [IDX_W-1:0]      mem_wr_link;
    alu_op_t               alu_op;
    logic [DELTA_BITS-1:0] alu_a, alu_b, alu_res;
    logic                  alu_ge;

    // helpers
    logic [TIME_W-1:0]     elapsed;
    logic [XW-1:0]         elapsed_x;
    logic [DELTA_BITS-1:0] interval;
    logic [DW-1:0]         delay_x;
    logic [DELTA_BITS-1:0] delay_sat;
    logic [CNT_W:0]        step_inc;
    logic                  more_left;
    state_t                adv_ret;

    dltq_slot_mem #(
        .ENTRY_COUNT (ENTRY_COUNT),
        .DELTA_BITS  (DELTA_BITS)
    ) u_mem (
        .clk      (clk),
        .rd_en    (mem_rd_en),
        .rd_addr  (mem_rd_addr),
        .rd_id    (q_id),
        .rd_delta (q_delta),
        .rd_link  (q_link),
        .we       (mem_we),
        .wr_addr  (mem_wr_addr),
        .wr_id    (mem_wr_id),
        .wr_delta (mem_wr_delta),
        .wr_link  (mem_wr_link)
    );

    dltq_alu #(
        .DELTA_BITS (DELTA_BITS)
    ) u_alu (
        .op  (alu_op),
        .a   (alu_a),
        .b   (alu_b),
        .res (alu_res),
        .ge  (alu_ge)
    );

    // elapsed time and delay, both clamped to the delta range
    always_comb
    begin
        elapsed   = now_reg - last_sync_reg;
        elapsed_x = XW'(elapsed);
        interval  = (elapsed_x > XW'(DELTA_MAX)) ? DELTA_MAX : elapsed_x[DELTA_BITS-1:0];
        delay_x   = DW'(delay_reg);
        delay_sat = (delay_x > DW'(DELTA_MAX)) ? DELTA_MAX : delay_x[DELTA_BITS-1:0];
        step_inc  = {1'b0, step_reg} + 1'b1;
        more_left = (step_inc < {1'b0, count_reg});
    end

    // where a time advance hands back control
    always_comb
    begin
        case (func_reg)
            FUNC_ADD:   adv_ret = S_ADD_CHK;
            FUNC_ALARM: adv_ret = S_AL_START;
            default:    adv_ret = S_DONE;
        endcase
    end

    // alu operand select
    always_comb
    begin
        alu_op = ALU_SUB;
        alu_a  = acc_reg;
        alu_b  = q_delta;
        case (state_reg)
            S_ADV_FIX, S_INS_FIX:
            begin
                alu_a = q_delta;
                alu_b = acc_reg;
            end
            S_RM_SUM:
            begin
                alu_op = ALU_ADD_SAT;
                alu_a  = q_delta;
                alu_b  = acc_reg;
            end
            default:
            begin
                alu_op = ALU_SUB;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next         = state_reg;
        func_next          = func_reg;
        head_next          = head_reg;
        count_next         = count_reg;
        last_sync_next     = last_sync_reg;
        used_next          = used_reg;
        step_next          = step_reg;
        has_prev_next      = has_prev_reg;
        adv_done_next      = adv_done_reg;
        status_next        = status_reg;
        exp_valid_next     = exp_valid_reg;
        exp_id_next        = exp_id_reg;
        out_valid_next     = out_valid_reg;
        out_status_next    = out_status_reg;
        out_exp_valid_next = out_exp_valid_reg;
        out_exp_id_next    = out_exp_id_reg;
        now_next           = now_reg;
        id_next            = id_reg;
        delay_next         = delay_reg;
        acc_next           = acc_reg;
        cur_next           = cur_reg;
        prev_next          = prev_reg;
        slot_next          = slot_reg;
        mem_rd_en          = 1'b0;
        mem_rd_addr        = head_reg;
        mem_we             = '0;
        mem_wr_addr        = cur_reg;
        mem_wr_id          = id_reg;
        mem_wr_delta       = alu_res;
        mem_wr_link        = cur_reg;

        // result beat taken
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    func_next      = req.func;
                    now_next       = req.now_time;
                    id_next        = req.entry_id;
                    delay_next     = req.delay;
                    status_next    = STATUS_OK;
                    exp_valid_next = 1'b0;
                    exp_id_next    = '0;
                    adv_done_next  = 1'b0;
                    case (req.func)
                        FUNC_REMOVE: state_next = S_RM_START;
                        FUNC_ALARM:  state_next = S_AL_START;
                        default:     state_next = S_ADV_START;
                    endcase
                end
            end

            // time advance: clamp interval, then drain it along the list
            S_ADV_START:
            begin
                last_sync_next = now_reg;
                if (now_reg < last_sync_reg || count_reg == '0)
                begin
                    state_next = adv_ret;
                end
                else
                begin
                    acc_next    = interval;
                    cur_next    = head_reg;
                    step_next   = '0;
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = head_reg;
                    state_next  = S_ADV_WALK;
                end
            end

            S_ADV_WALK:
            begin
                if (alu_ge)
                begin
                    acc_next        = alu_res;
                    mem_we.delta_en = 1'b1;
                    mem_wr_addr     = cur_reg;
                    mem_wr_delta    = '0;
                    if (more_left)
                    begin
                        step_next   = step_inc[CNT_W-1:0];
                        cur_next    = q_link;
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = q_link;
                    end
                    else
                    begin
                        state_next = adv_ret;
                    end
                end
                else
                begin
                    state_next = S_ADV_FIX;
                end
            end

            S_ADV_FIX:
            begin
                mem_we.delta_en = 1'b1;
                mem_wr_addr     = cur_reg;
                mem_wr_delta    = alu_res;
                state_next      = adv_ret;
            end

            // add: capacity, then duplicate walk
            S_ADD_CHK:
            begin
                slot_next = '0;
                if (count_reg == CNT_W'(ENTRY_COUNT))
                begin
                    status_next = STATUS_FULL;
                    state_next  = S_DONE;
                end
                else if (count_reg == '0)
                begin
                    state_next = S_FREE_SCAN;
                end
                else
                begin
                    step_next   = '0;
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = head_reg;
                    state_next  = S_DUP_WALK;
                end
            end

            S_DUP_WALK:
            begin
                if (q_id == id_reg)
                begin
                    status_next = STATUS_DUP;
                    state_next  = S_DONE;
                end
                else if (more_left)
                begin
                    step_next   = step_inc[CNT_W-1:0];
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = q_link;
                end
                else
                begin
                    state_next = S_FREE_SCAN;
                end
            end

            // lowest unused slot, one per cycle
            S_FREE_SCAN:
            begin
                if (!used_reg[slot_reg])
                begin
                    state_next = S_INS_START;
                end
                else
                begin
                    slot_next = slot_reg + 1'b1;
                end
            end

            S_INS_START:
            begin
                acc_next      = delay_sat;
                has_prev_next = 1'b0;
                if (count_reg == '0)
                begin
                    cur_next   = '0;
                    state_next = S_INS_NEW;
                end
                else
                begin
                    cur_next    = head_reg;
                    step_next   = '0;
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = head_reg;
                    state_next  = S_INS_WALK;
                end
            end

            // skip entries due no later than the new one
            S_INS_WALK:
            begin
                if (alu_ge)
                begin
                    acc_next      = alu_res;
                    prev_next     = cur_reg;
                    has_prev_next = 1'b1;
                    if (more_left)
                    begin
                        step_next   = step_inc[CNT_W-1:0];
                        cur_next    = q_link;
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = q_link;
                    end
                    else
                    begin
                        cur_next   = '0;
                        state_next = S_INS_NEW;
                    end
                end
                else
                begin
                    state_next = S_INS_FIX;
                end
            end

            S_INS_FIX:
            begin
                mem_we.delta_en = 1'b1;
                mem_wr_addr     = cur_reg;
                mem_wr_delta    = alu_res;
                state_next      = S_INS_NEW;
            end

            S_INS_NEW:
            begin
                mem_we       = '{id_en: 1'b1, delta_en: 1'b1, link_en: 1'b1};
                mem_wr_addr  = slot_reg;
                mem_wr_id    = id_reg;
                mem_wr_delta = acc_reg;
                mem_wr_link  = cur_reg;
                state_next   = S_INS_LINK;
            end

            S_INS_LINK:
            begin
                if (has_prev_reg)
                begin
                    mem_we.link_en = 1'b1;
                    mem_wr_addr    = prev_reg;
                    mem_wr_link    = slot_reg;
                end
                else
                begin
                    head_next = slot_reg;
                end
                used_next[slot_reg] = 1'b1;
                count_next          = count_reg + 1'b1;
                state_next          = S_DONE;
            end

            // remove: find id, fold its delta into the successor
            S_RM_START:
            begin
                if (count_reg == '0)
                begin
                    status_next = STATUS_MISSING;
                    state_next  = S_DONE;
                end
                else
                begin
                    cur_next      = head_reg;
                    has_prev_next = 1'b0;
                    step_next     = '0;
                    mem_rd_en     = 1'b1;
                    mem_rd_addr   = head_reg;
                    state_next    = S_RM_WALK;
                end
            end

            S_RM_WALK:
            begin
                if (q_id == id_reg)
                begin
                    slot_next = cur_reg;
                    acc_next  = q_delta;
                    cur_next  = q_link;
                    if (more_left)
                    begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = q_link;
                        state_next  = S_RM_SUM;
                    end
                    else
                    begin
                        state_next = S_RM_LINK;
                    end
                end
                else if (more_left)
                begin
                    prev_next     = cur_reg;
                    has_prev_next = 1'b1;
                    cur_next      = q_link;
                    step_next     = step_inc[CNT_W-1:0];
                    mem_rd_en     = 1'b1;
                    mem_rd_addr   = q_link;
                end
                else
                begin
                    status_next = STATUS_MISSING;
                    state_next  = S_DONE;
                end
            end

            S_RM_SUM:
            begin
                mem_we.delta_en = 1'b1;
                mem_wr_addr     = cur_reg;
                mem_wr_delta    = alu_res;
                state_next      = S_RM_LINK;
            end

            S_RM_LINK:
            begin
                if (has_prev_reg)
                begin
                    mem_we.link_en = 1'b1;
                    mem_wr_addr    = prev_reg;
                    mem_wr_link    = cur_reg;
                end
                else
                begin
                    head_next = cur_reg;
                end
                used_next[slot_reg] = 1'b0;
                count_next          = count_reg - 1'b1;
                state_next          = S_DONE;
            end

            // alarm: advance time unless the head is already due
            S_AL_START:
            begin
                if (count_reg == '0)
                begin
                    adv_done_next = 1'b1;
                    state_next    = adv_done_reg ? S_DONE : S_ADV_START;
                end
                else
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = head_reg;
                    state_next  = S_AL_CHK;
                end
            end

            S_AL_CHK:
            begin
                if (q_delta == '0)
                begin
                    // due head leaves with zero delta, successor keeps its own
                    exp_valid_next      = 1'b1;
                    exp_id_next         = q_id;
                    head_next           = q_link;
                    used_next[head_reg] = 1'b0;
                    count_next          = count_reg - 1'b1;
                    state_next          = S_DONE;
                end
                else
                begin
                    adv_done_next = 1'b1;
                    state_next    = adv_done_reg ? S_DONE : S_ADV_START;
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next     = 1'b1;
                    out_status_next    = status_reg;
                    out_exp_valid_next = exp_valid_reg;
                    out_exp_id_next    = exp_id_reg;
                    state_next         = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            func_reg          <= FUNC_SYNC;
            head_reg          <= '0;
            count_reg         <= '0;
            last_sync_reg     <= '0;
            used_reg          <= '0;
            step_reg          <= '0;
            has_prev_reg      <= 1'b0;
            adv_done_reg      <= 1'b0;
            status_reg        <= STATUS_OK;
            exp_valid_reg     <= 1'b0;
            exp_id_reg        <= '0;
            out_valid_reg     <= 1'b0;
            out_status_reg    <= STATUS_OK;
            out_exp_valid_reg <= 1'b0;
            out_exp_id_reg    <= '0;
        end
        else
        begin
            state_reg         <= state_next;
            func_reg          <= func_next;
            head_reg          <= head_next;
            count_reg         <= count_next;
            last_sync_reg     <= last_sync_next;
            used_reg          <= used_next;
            step_reg          <= step_next;
            has_prev_reg      <= has_prev_next;
            adv_done_reg      <= adv_done_next;
            status_reg        <= status_next;
            exp_valid_reg     <= exp_valid_next;
            exp_id_reg        <= exp_id_next;
            out_valid_reg     <= out_valid_next;
            out_status_reg    <= out_status_next;
            out_exp_valid_reg <= out_exp_valid_next;
            out_exp_id_reg    <= out_exp_id_next;
        end
    end

    // working data, no reset
    always_ff @(posedge clk)
    begin
        now_reg   <= now_next;
        id_reg    <= id_next;
        delay_reg <= delay_next;
        acc_reg   <= acc_next;
        cur_reg   <= cur_next;
        prev_reg  <= prev_next;
        slot_reg  <= slot_next;
    end

    // ports
    assign req.ready         = (state_reg == S_IDLE);
    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.expired_valid = out_exp_valid_reg;
    assign rsp.expired_id    = out_exp_id_reg;

    // checks
    `DLTQ_ASSERT_ALWAYS(a_count_bound, count_reg <= CNT_W'(ENTRY_COUNT),
        "entry count overflow")
    `DLTQ_ASSERT_ALWAYS(a_used_matches_count, $countones(used_reg) == int'(count_reg),
        "used slots and count disagree")
    `DLTQ_ASSERT_NEXT(a_insert_counts, state_reg == S_INS_LINK,
        count_reg == $past(count_reg) + 1'b1, "insert did not bump count")
    `DLTQ_ASSERT_IMP(a_result_from_done, $rose(out_valid_reg), $past(state_reg == S_DONE),
        "result beat outside done")

endmodule

[dv/delta_list_timer_queue_tb.sv]
`timescale 1ns / 1ps

module delta_list_timer_queue_tb;
    import dltq_pkg::*;

    localparam int SLOTS = DLTQ_ENTRY_COUNT;
    localparam int DB    = DLTQ_DELTA_BITS;
    localparam bit [63:0] DELTA_MAX = (64'd1 << DB) - 64'd1;
    localparam int IDLE_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 400;
    localparam bit [TIME_W-1:0] TIME_TOP = '1;
    localparam bit [DELAY_W-1:0] DELAY_TOP = '1;

    // what one command should return
    typedef struct {
        status_t         status;
        bit              fired;
        bit [ID_W-1:0]   fired_id;
    } timer_outcome_t;

    // delta-list predictor plus the queue of outcomes still owed by the block
    class timer_queue_scoreboard;
        bit [ID_W-1:0]   ids[SLOTS];
        bit [DB-1:0]     deltas[SLOTS];
        int              nexts[SLOTS];
        bit              used[SLOTS];
        int              head;
        int              count;
        bit [TIME_W-1:0] last_sync;
        timer_outcome_t  due_outcomes[$];
        int              mismatches;

        function new();
            foreach (ids[k])
            begin
                ids[k] = '0;
                deltas[k] = '0;
                nexts[k] = 0;
                used[k] = 1'b0;
            end
            head = 0;
            count = 0;
            last_sync = '0;
            mismatches = 0;
        endfunction

        // expire whatever ran out since the last sync
        function void advance_clock(bit [TIME_W-1:0] now);
            bit [63:0] span;
            int idx;
            int i;
            if (now < last_sync)
            begin
                last_sync = now;
                return;
            end
            span = 64'(now - last_sync);
            if (span > DELTA_MAX)
                span = DELTA_MAX;
            last_sync = now;
            idx = head;
            i = 0;
            while (i < count && span >= 64'(deltas[idx]))
            begin
                span -= 64'(deltas[idx]);
                deltas[idx] = '0;
                idx = nexts[idx];
                i++;
            end
            if (i < count)
                deltas[idx] = deltas[idx] - span[DB-1:0];
        endfunction

        // list position of an id, or -1
        function int locate_timer(bit [ID_W-1:0] id, output int slot, output int prev);
            int idx;
            int prior;
            idx = head;
            prior = -1;
            slot = -1;
            prev = -1;
            for (int i = 0; i < count; i++)
            begin
                if (ids[idx] == id)
                begin
                    slot = idx;
                    prev = prior;
                    return i;
                end
                prior = idx;
                idx = nexts[idx];
            end
            return -1;
        endfunction

        // ordered insert, behind any entry with the same deadline
        function status_t insert_timer(bit [ID_W-1:0] id, bit [DELAY_W-1:0] dly);
            bit [63:0] rem;
            int idx;
            int prev;
            int slot;
            int s;
            int p;
            int i;
            if (count >= SLOTS)
                return STATUS_FULL;
            if (locate_timer(id, s, p) >= 0)
                return STATUS_DUP;
            slot = -1;
            for (int k = SLOTS - 1; k >= 0; k--)
                if (!used[k])
                    slot = k;
            if (slot < 0)
                return STATUS_FULL;
            rem = (64'(dly) > DELTA_MAX) ? DELTA_MAX : 64'(dly);
            idx = head;
            prev = -1;
            i = 0;
            while (i < count && rem >= 64'(deltas[idx]))
            begin
                rem -= 64'(deltas[idx]);
                prev = idx;
                idx = nexts[idx];
                i++;
            end
            if (i < count)
            begin
                deltas[idx] = deltas[idx] - rem[DB-1:0];
                nexts[slot] = idx;
            end
            else
                nexts[slot] = 0;
            deltas[slot] = rem[DB-1:0];
            ids[slot] = id;
            used[slot] = 1'b1;
            if (prev < 0)
                head = slot;
            else
                nexts[prev] = slot;
            count++;
            return STATUS_OK;
        endfunction

        // take a slot out and hand its delta to the successor
        function void unlink_timer(int pos, int slot, int prev);
            int nxt;
            bit [64:0] sum;
            nxt = nexts[slot];
            if (pos + 1 < count)
            begin
                sum = 65'(deltas[nxt]) + 65'(deltas[slot]);
                if (sum > 65'(DELTA_MAX))
                    sum = 65'(DELTA_MAX);
                deltas[nxt] = sum[DB-1:0];
            end
            if (prev < 0)
                head = nxt;
            else
                nexts[prev] = nxt;
            used[slot] = 1'b0;
            count--;
        endfunction

        function void note_command(func_t fn, bit [TIME_W-1:0] now, bit [ID_W-1:0] id,
                                   bit [DELAY_W-1:0] dly);
            timer_outcome_t res;
            int pos;
            int slot;
            int prev;
            res.status = STATUS_OK;
            res.fired = 1'b0;
            res.fired_id = '0;
            case (fn)
                FUNC_SYNC:
                    advance_clock(now);
                FUNC_ADD:
                begin
                    advance_clock(now);
                    res.status = insert_timer(id, dly);
                end
                FUNC_REMOVE:
                begin
                    pos = locate_timer(id, slot, prev);
                    if (pos < 0)
                        res.status = STATUS_MISSING;
                    else
                        unlink_timer(pos, slot, prev);
                end
                default:
                begin
                    // an expired head blocks the time update
                    if (count == 0 || deltas[head] != '0)
                        advance_clock(now);
                    if (count > 0 && deltas[head] == '0)
                    begin
                        res.fired = 1'b1;
                        res.fired_id = ids[head];
                        unlink_timer(0, head, -1);
                    end
                end
            endcase
            due_outcomes.push_back(res);
        endfunction

        function void check_result(status_t st, logic fired, logic [ID_W-1:0] fired_id);
            timer_outcome_t want;
            if (due_outcomes.size() == 0)
            begin
                $error("result beat with no command outstanding");
                mismatches++;
                return;
            end
            want = due_outcomes.pop_front();
            if (st !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, st);
                mismatches++;
            end
            if (fired !== want.fired)
            begin
                $error("expired_valid: expected %0d, got %0d", want.fired, fired);
                mismatches++;
            end
            if (fired_id !== want.fired_id)
            begin
                $error("expired_id: expected %0d, got %0d", want.fired_id, fired_id);
                mismatches++;
            end
        endfunction

        function int outstanding();
            return due_outcomes.size();
        endfunction

        // id of some queued timer, for removes that hit
        function bit pick_queued(output bit [ID_W-1:0] id);
            int idx;
            id = '0;
            if (count == 0)
                return 1'b0;
            idx = head;
            repeat ($urandom_range(0, count - 1))
                idx = nexts[idx];
            id = ids[idx];
            return 1'b1;
        endfunction
    endclass

    logic clk;
    logic rst_n;
    dltq_req_if req_ch ();
    dltq_rsp_if rsp_ch ();

    timer_queue_scoreboard sb = new();
    bit                    calm;
    bit [TIME_W-1:0]       clock_us;
    bit [DELAY_W-1:0]      last_delay;
    int                    quiet_cycles;

    delta_list_timer_queue uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // mostly short gaps, a few long ones, none in calm stretches
    function automatic int pick_gap();
        int roll;
        if (calm)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // time base: mostly forward, sometimes backwards or far away
    function automatic bit [TIME_W-1:0] step_clock();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 85)
            clock_us = clock_us + TIME_W'($urandom_range(0, 120));
        else if (roll < 91)
            clock_us = (clock_us > 500) ? clock_us - TIME_W'($urandom_range(1, 500)) : '0;
        else if (roll < 94)
            clock_us = TIME_W'({$urandom, $urandom});
        return clock_us;
    endfunction

    function automatic bit [DELAY_W-1:0] pick_delay();
        int roll;
        roll = $urandom_range(0, 99);
        // reusing the previous delay makes equal deadlines likely
        if (roll < 60)
            last_delay = DELAY_W'($urandom_range(0, 400));
        else if (roll < 75)
            last_delay = last_delay;
        else if (roll < 85)
            last_delay = '0;
        else if (roll < 95)
            last_delay = DELAY_W'({$urandom, $urandom});
        else
            last_delay = DELAY_TOP;
        return last_delay;
    endfunction

    function automatic bit [ID_W-1:0] pick_id();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return ID_W'($urandom_range(0, 23));
        if (roll < 80)
            return '1;
        if (roll < 85)
            return '0;
        return ID_W'($urandom);
    endfunction

    // one request beat, held until accepted
    task automatic send_cmd(func_t fn, bit [TIME_W-1:0] now, bit [ID_W-1:0] id,
                            bit [DELAY_W-1:0] dly);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.func     <= fn;
        req_ch.now_time <= now;
        req_ch.entry_id <= id;
        req_ch.delay    <= dly;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    // hold off until every owed result is back
    task automatic drain_wait();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0)
            @(posedge clk);
    endtask

    task automatic run_directed();
        bit [DELAY_W-1:0] dly;
        calm = 1'b1;
        send_cmd(FUNC_ALARM, '0, '0, '0);
        send_cmd(FUNC_SYNC, TIME_W'(100), '0, '0);
        // fill every slot: zero delay head, equal deadlines, widest delay last
        for (int k = 0; k < SLOTS; k++)
        begin
            dly = (k == SLOTS - 1) ? DELAY_TOP : DELAY_W'((k % 4) * 25);
            send_cmd(FUNC_ADD, TIME_W'(100), (k == SLOTS - 1) ? '1 : ID_W'(k), dly);
        end
        // full wins over duplicate
        send_cmd(FUNC_ADD, TIME_W'(100), '0, DELAY_W'(5));
        send_cmd(FUNC_ADD, TIME_W'(100), ID_W'(200), DELAY_W'(5));
        send_cmd(FUNC_REMOVE, '0, ID_W'(77), '0);
        send_cmd(FUNC_REMOVE, '0, ID_W'(5), '0);
        send_cmd(FUNC_ALARM, TIME_W'(100), '0, '0);
        // backwards, then a jump that saturates the elapsed time
        send_cmd(FUNC_SYNC, TIME_W'(50), '0, '0);
        send_cmd(FUNC_SYNC, TIME_TOP, '0, '0);
        send_cmd(FUNC_ALARM, TIME_TOP, '1, DELAY_TOP);
        send_cmd(FUNC_SYNC, '0, '0, '0);
        clock_us = '0;
    endtask

    task automatic run_random(int n_items);
        int sent;
        int phase_len;
        int kind;
        int roll;
        func_t fn;
        bit [ID_W-1:0] id;
        sent = 0;
        while (sent < n_items)
        begin
            phase_len = $urandom_range(20, 60);
            kind = $urandom_range(0, 2);
            calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 4) == 0)
                drain_wait();
            repeat (phase_len)
            begin
                roll = $urandom_range(0, 99);
                // fill-heavy, drain-heavy or mixed phases
                case (kind)
                    0: fn = (roll < 65) ? FUNC_ADD : (roll < 75) ? FUNC_ALARM :
                            (roll < 88) ? FUNC_REMOVE : FUNC_SYNC;
                    1: fn = (roll < 15) ? FUNC_ADD : (roll < 70) ? FUNC_ALARM :
                            (roll < 90) ? FUNC_REMOVE : FUNC_SYNC;
                    default: fn = (roll < 40) ? FUNC_ADD : (roll < 70) ? FUNC_ALARM :
                            (roll < 85) ? FUNC_REMOVE : FUNC_SYNC;
                endcase
                if (fn == FUNC_REMOVE)
                begin
                    if (!($urandom_range(0, 99) < 70 && sb.pick_queued(id)))
                        id = pick_id();
                    send_cmd(fn, TIME_W'({$urandom, $urandom}), id, DELAY_W'({$urandom, $urandom}));
                end
                else if (fn == FUNC_ADD)
                    send_cmd(fn, step_clock(), pick_id(), pick_delay());
                else
                    send_cmd(fn, step_clock(), ID_W'($urandom), DELAY_W'({$urandom, $urandom}));
                sent++;
            end
        end
    endtask

    // response side back-pressure
    initial
    begin
        int stall;
        stall = 0;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall--;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                if ($urandom_range(0, 2) == 0)
                    stall = pick_gap();
            end
        end
    end

    // beat monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (req_ch.valid && req_ch.ready)
            begin
                sb.note_command(req_ch.func, req_ch.now_time, req_ch.entry_id, req_ch.delay);
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                sb.check_result(rsp_ch.status, rsp_ch.expired_valid, rsp_ch.expired_id);
            end
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("delta_list_timer_queue_tb: done, errors");
                $finish;
            end
        end
    end

    // main sequence
    initial
    begin
        rst_n = 1'b0;
        calm = 1'b1;
        clock_us = '0;
        last_delay = '0;
        quiet_cycles = 0;
        req_ch.valid = 1'b0;
        req_ch.func = FUNC_SYNC;
        req_ch.now_time = '0;
        req_ch.entry_id = '0;
        req_ch.delay = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        drain_wait();
        run_random(RANDOM_ITEMS);
        drain_wait();
        repeat (80) @(posedge clk);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("delta_list_timer_queue_tb: done, clean");
        else
            $display("delta_list_timer_queue_tb: done, errors");
        $finish;
    end

endmodule
